// ===== sv/dmwbc_pkg.sv =====
// Shared constants, codes and controller/datapath interface types for the cache.
package dmwbc_pkg;

    localparam int LINE_COUNT   = 64;
    localparam int BLOCK_BYTES  = 16;
    localparam int WORD_BYTES   = 4;
    localparam int MEMORY_BYTES = 65536;

    localparam int ADDR_W   = 16;
    localparam int DATA_W   = 32;
    localparam int COST_W   = 8;
    localparam int COUNT_W  = 32;
    localparam int OP_W     = 2;
    localparam int CFG_IDX_W = 2;

    localparam int BLOCK_W   = BLOCK_BYTES * 8;
    localparam int WORD_W    = WORD_BYTES * 8;
    localparam int OFF_W     = $clog2(BLOCK_BYTES);
    localparam int WOFF_W    = $clog2(WORD_BYTES);
    localparam int SLOT_W    = OFF_W - WOFF_W;
    localparam int IDX_W     = $clog2(LINE_COUNT);
    localparam int TAG_W     = ADDR_W - OFF_W - IDX_W;
    localparam int BACK_ROWS = MEMORY_BYTES / BLOCK_BYTES;
    localparam int BROW_W    = $clog2(BACK_ROWS);

    localparam logic [OP_W-1:0] OP_READ  = 2'd0;
    localparam logic [OP_W-1:0] OP_WRITE = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_L1_READ   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_L1_WRITE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MEM_READ  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MEM_WRITE = 2'd3;

    typedef struct packed {
        logic clr_step;
        logic load;
        logic zero_count;
        logic check;
        logic evict;
        logic fill;
        logic access;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic clr_last;
        logic is_clear;
        logic is_rw;
        logic range_err;
        logic hit;
        logic dirty_victim;
    } t_stat;

endpackage

// ===== sv/dmwbc_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
module dmwbc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// ===== sv/dmwbc_ctrl.sv =====
// Controller state machine that sequences clearing, lookup, write-back, fill and access.
module dmwbc_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    input  dmwbc_pkg::t_stat i_stat,
    output dmwbc_pkg::t_cmd  o_cmd,
    output logic            busy,
    output logic            o_done
);
    import dmwbc_pkg::*;

    localparam logic [2:0] S_CLEAR  = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_LOOKUP = 3'd2;
    localparam logic [2:0] S_CMP    = 3'd3;
    localparam logic [2:0] S_FILL   = 3'd4;
    localparam logic [2:0] S_ACCESS = 3'd5;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic       r_done;
    t_cmd       w_cmd;

    always_comb begin
        n_state = r_state;
        w_cmd   = '0;
        unique case (r_state)
            S_CLEAR: begin
                w_cmd.clr_step = 1'b1;
                if (i_stat.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (start) begin
                    w_cmd.load = 1'b1;
                    n_state    = S_LOOKUP;
                end
            end
            S_LOOKUP: begin
                priority if (i_stat.is_clear) begin
                    w_cmd.zero_count = 1'b1;
                    w_cmd.finish     = 1'b1;
                    n_state          = S_IDLE;
                end else if (!i_stat.is_rw || i_stat.range_err) begin
                    w_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end else begin
                    n_state = S_CMP;
                end
            end
            S_CMP: begin
                w_cmd.check = 1'b1;
                if (i_stat.hit) begin
                    n_state = S_ACCESS;
                end else begin
                    w_cmd.evict = i_stat.dirty_victim;
                    n_state     = S_FILL;
                end
            end
            S_FILL: begin
                w_cmd.fill = 1'b1;
                n_state    = S_ACCESS;
            end
            S_ACCESS: begin
                w_cmd.access = 1'b1;
                w_cmd.finish = 1'b1;
                n_state      = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= w_cmd.finish;
        end
    end

    assign o_cmd  = w_cmd;
    assign busy   = (r_state != S_IDLE);
    assign o_done = r_done;

`ifndef SYNTHESIS
    a_done_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> ($past(r_state) == S_LOOKUP || $past(r_state) == S_ACCESS))
        else $error("result strobe without a finishing state");

    a_fill_after_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FILL) |-> ($past(r_state) == S_CMP && !$past(i_stat.hit)))
        else $error("fill entered without a miss");
`endif

endmodule

// ===== sv/dmwbc_dp.sv =====
// Datapath with the line, tag and backing memories, line state, cost registers and counter.
module dmwbc_dp (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  dmwbc_pkg::t_cmd                     i_cmd,
    output dmwbc_pkg::t_stat                    o_stat,
    input  logic                                i_cfg_we,
    input  logic [dmwbc_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [dmwbc_pkg::COST_W-1:0]        i_cfg_data,
    input  logic [dmwbc_pkg::OP_W-1:0]          i_op,
    input  logic [dmwbc_pkg::ADDR_W-1:0]        i_address,
    input  logic [dmwbc_pkg::DATA_W-1:0]        i_write_data,
    output logic [dmwbc_pkg::DATA_W-1:0]        o_read_data,
    output logic                                o_hit,
    output logic                                o_wrote_back,
    output logic                                o_range_error,
    output logic [dmwbc_pkg::COUNT_W-1:0]       o_elapsed
);
    import dmwbc_pkg::*;

    logic [COST_W-1:0]  r_l1_rd;
    logic [COST_W-1:0]  r_l1_wr;
    logic [COST_W-1:0]  r_mem_rd;
    logic [COST_W-1:0]  r_mem_wr;

    logic [OP_W-1:0]    r_op;
    logic [ADDR_W-1:0]  r_addr;
    logic [DATA_W-1:0]  r_wdata;
    logic [BLOCK_W-1:0] r_line;
    logic               r_hit;
    logic               r_wb;
    logic [COUNT_W-1:0] r_elapsed;
    logic [COUNT_W-1:0] n_elapsed;
    logic [BROW_W-1:0]  r_clr_row;
    logic [LINE_COUNT-1:0] r_valid;
    logic [LINE_COUNT-1:0] r_dirty;

    logic [IDX_W-1:0]   w_idx;
    logic [TAG_W-1:0]   w_tag;
    logic [SLOT_W-1:0]  w_slot;
    logic [BROW_W-1:0]  w_base_row;
    logic [BROW_W-1:0]  w_victim_row;
    logic [ADDR_W:0]    w_base_end;
    logic               w_range_err;
    logic               w_hit;

    logic [TAG_W-1:0]   w_tag_rdata;
    logic [BLOCK_W-1:0] w_line_rdata;
    logic [BLOCK_W-1:0] w_back_rdata;
    logic               w_back_we;
    logic [BROW_W-1:0]  w_back_waddr;
    logic [BLOCK_W-1:0] w_back_wdata;
    logic [BLOCK_W-1:0] w_merged;
    logic [WORD_W-1:0]  w_word;

    assign w_idx        = r_addr[OFF_W +: IDX_W];
    assign w_tag        = r_addr[ADDR_W-1 -: TAG_W];
    assign w_slot       = r_addr[WOFF_W +: SLOT_W];
    assign w_base_row   = r_addr[OFF_W +: BROW_W];
    assign w_victim_row = {w_tag_rdata, w_idx};
    assign w_base_end   = {1'b0, r_addr[ADDR_W-1:OFF_W], {OFF_W{1'b0}}}
                          + (ADDR_W+1)'(BLOCK_BYTES);
    assign w_range_err  = (32'(w_base_end) > 32'(MEMORY_BYTES));
    assign w_hit        = r_valid[w_idx] && (w_tag_rdata == w_tag);

    assign o_stat.clr_last     = (r_clr_row == BROW_W'(BACK_ROWS - 1));
    assign o_stat.is_clear     = (r_op == OP_CLEAR);
    assign o_stat.is_rw        = (r_op == OP_READ) || (r_op == OP_WRITE);
    assign o_stat.range_err    = w_range_err;
    assign o_stat.hit          = w_hit;
    assign o_stat.dirty_victim = r_valid[w_idx] && r_dirty[w_idx];

    assign w_word = r_line[w_slot*WORD_W +: WORD_W];

    always_comb begin
        w_merged = r_line;
        if (r_op == OP_WRITE) begin
            w_merged[w_slot*WORD_W +: WORD_W] = r_wdata[WORD_W-1:0];
        end
    end

    always_comb begin
        w_back_we    = i_cmd.clr_step || i_cmd.evict;
        w_back_waddr = i_cmd.clr_step ? r_clr_row : w_victim_row;
        w_back_wdata = i_cmd.clr_step ? '0 : w_line_rdata;
    end

    dmwbc_ram #(.WIDTH(BLOCK_W), .DEPTH(BACK_ROWS)) u_back_ram (
        .i_clk   (i_clk),
        .i_we    (w_back_we),
        .i_waddr (w_back_waddr),
        .i_wdata (w_back_wdata),
        .i_raddr (w_base_row),
        .o_rdata (w_back_rdata)
    );

    dmwbc_ram #(.WIDTH(BLOCK_W), .DEPTH(LINE_COUNT)) u_line_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.access),
        .i_waddr (w_idx),
        .i_wdata (w_merged),
        .i_raddr (w_idx),
        .o_rdata (w_line_rdata)
    );

    dmwbc_ram #(.WIDTH(TAG_W), .DEPTH(LINE_COUNT)) u_tag_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.fill),
        .i_waddr (w_idx),
        .i_wdata (w_tag),
        .i_raddr (w_idx),
        .o_rdata (w_tag_rdata)
    );

    always_comb begin
        priority if (i_cmd.zero_count) begin
            n_elapsed = '0;
        end else if (i_cmd.evict) begin
            n_elapsed = r_elapsed + COUNT_W'(r_mem_wr);
        end else if (i_cmd.fill) begin
            n_elapsed = r_elapsed + COUNT_W'(r_mem_rd);
        end else if (i_cmd.access) begin
            n_elapsed = r_elapsed + COUNT_W'((r_op == OP_READ) ? r_l1_rd : r_l1_wr);
        end else begin
            n_elapsed = r_elapsed;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_l1_rd   <= COST_W'(1);
            r_l1_wr   <= COST_W'(1);
            r_mem_rd  <= COST_W'(100);
            r_mem_wr  <= COST_W'(100);
            r_elapsed <= '0;
            r_clr_row <= '0;
            r_valid   <= '0;
            r_dirty   <= '0;
            r_op      <= OP_READ;
            r_hit     <= 1'b0;
            r_wb      <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_L1_READ:   r_l1_rd  <= i_cfg_data;
                    CFG_L1_WRITE:  r_l1_wr  <= i_cfg_data;
                    CFG_MEM_READ:  r_mem_rd <= i_cfg_data;
                    CFG_MEM_WRITE: r_mem_wr <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            r_elapsed <= n_elapsed;
            if (i_cmd.clr_step) begin
                r_clr_row <= r_clr_row + BROW_W'(1);
            end
            if (i_cmd.load) begin
                r_op  <= i_op;
                r_hit <= 1'b0;
                r_wb  <= 1'b0;
            end
            if (i_cmd.check) begin
                r_hit <= w_hit;
            end
            if (i_cmd.evict) begin
                r_wb <= 1'b1;
            end
            if (i_cmd.fill) begin
                r_valid[w_idx] <= 1'b1;
                r_dirty[w_idx] <= 1'b0;
            end
            if (i_cmd.access && (r_op == OP_WRITE)) begin
                r_dirty[w_idx] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_addr  <= i_address;
            r_wdata <= i_write_data;
        end
        if (i_cmd.check) begin
            r_line <= w_hit ? w_line_rdata : w_back_rdata;
        end
        if (i_cmd.finish) begin
            o_read_data   <= (i_cmd.access && (r_op == OP_READ))
                             ? DATA_W'(w_word) : '0;
            o_hit         <= r_hit;
            o_wrote_back  <= r_wb;
            o_range_error <= o_stat.is_rw && w_range_err;
            o_elapsed     <= n_elapsed;
        end
    end

`ifndef SYNTHESIS
    a_access_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.access |-> r_valid[w_idx])
        else $error("line access on an invalid line");

    a_victim_apart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.evict |-> (w_victim_row != w_base_row))
        else $error("write-back row collides with fill row");

    a_hit_no_wb: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.finish |=> !(o_hit && o_wrote_back))
        else $error("word reported both as hit and as written back");
`endif

endmodule

// ===== sv/direct_mapped_write_back_cache.sv =====
// Top level of the direct-mapped write-back cache with backing memory and cost counter.
// A word taken while idle passes the lookup step; a counter clear, an unused op or an out-of-range
// address ends there, others go on through compare, a fill on a miss and the line access.
// The controller's lookup, compare, fill and access steps lie around the registered memory
// reads; a new word is taken in the cycle its predecessor's result is shown.
// After reset the block stays busy while it zeroes the backing memory.
module direct_mapped_write_back_cache (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [dmwbc_pkg::OP_W-1:0]        i_op,
    input  logic [dmwbc_pkg::ADDR_W-1:0]      i_address,
    input  logic [dmwbc_pkg::DATA_W-1:0]      i_write_data,
    input  logic                              i_cfg_we,
    input  logic [dmwbc_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [dmwbc_pkg::COST_W-1:0]      i_cfg_data,
    output logic                              o_done,
    output logic [dmwbc_pkg::DATA_W-1:0]      o_read_data,
    output logic                              o_hit,
    output logic                              o_wrote_back,
    output logic                              o_range_error,
    output logic [dmwbc_pkg::COUNT_W-1:0]     o_elapsed
);
    import dmwbc_pkg::*;

    t_cmd  w_cmd;
    t_stat w_stat;

    dmwbc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd),
        .busy    (busy),
        .o_done  (o_done)
    );

    dmwbc_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_stat        (w_stat),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_op          (i_op),
        .i_address     (i_address),
        .i_write_data  (i_write_data),
        .o_read_data   (o_read_data),
        .o_hit         (o_hit),
        .o_wrote_back  (o_wrote_back),
        .o_range_error (o_range_error),
        .o_elapsed     (o_elapsed)
    );

endmodule

// ===== sim/direct_mapped_write_back_cache_tb.sv =====
// Self-checking testbench for the direct-mapped write-back cache and its access-cost counter.
`timescale 1ns / 1ps

module direct_mapped_write_back_cache_tb;
    import dmwbc_pkg::*;

    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    localparam int CACHE_BYTES = LINE_COUNT * BLOCK_BYTES;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [ADDR_W-1:0] address;
        logic [DATA_W-1:0] write_data;
    } t_access;

    typedef struct packed {
        logic [DATA_W-1:0]  read_data;
        logic               hit;
        logic               wrote_back;
        logic               range_error;
        logic [COUNT_W-1:0] elapsed;
    } t_reply;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 busy;
    logic [OP_W-1:0]      i_op = '0;
    logic [ADDR_W-1:0]    i_address = '0;
    logic [DATA_W-1:0]    i_write_data = '0;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [COST_W-1:0]    i_cfg_data = '0;
    logic                 o_done;
    logic [DATA_W-1:0]    o_read_data;
    logic                 o_hit;
    logic                 o_wrote_back;
    logic                 o_range_error;
    logic [COUNT_W-1:0]   o_elapsed;

    direct_mapped_write_back_cache uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_op          (i_op),
        .i_address     (i_address),
        .i_write_data  (i_write_data),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_done        (o_done),
        .o_read_data   (o_read_data),
        .o_hit         (o_hit),
        .o_wrote_back  (o_wrote_back),
        .o_range_error (o_range_error),
        .o_elapsed     (o_elapsed)
    );

    always #5 i_clk = ~i_clk;

    logic [7:0]         line_data [0:CACHE_BYTES-1];
    logic [TAG_W-1:0]   line_tag [0:LINE_COUNT-1];
    logic               line_valid [0:LINE_COUNT-1];
    logic               line_dirty [0:LINE_COUNT-1];
    logic [7:0]         backing_data [0:MEMORY_BYTES-1];
    logic [COUNT_W-1:0] elapsed_model;
    logic [COST_W-1:0]  l1_read_cost;
    logic [COST_W-1:0]  l1_write_cost;
    logic [COST_W-1:0]  mem_read_cost;
    logic [COST_W-1:0]  mem_write_cost;

    t_access access_queue[$];
    t_reply  predicted_replies[$];
    int      words_queued = 0;
    int      words_accepted = 0;
    int      mismatch_count = 0;

    task automatic predict_access(input t_access a, output t_reply r);
        logic [ADDR_W-1:0] word_addr;
        int off;
        int idx;
        logic [TAG_W-1:0] tg;
        int victim_base;
        int block_base;
        r = '0;
        if (a.op == OP_CLEAR) begin
            elapsed_model = '0;
        end else if (a.op == OP_READ || a.op == OP_WRITE) begin
            word_addr = a.address & ~ADDR_W'(WORD_BYTES - 1);
            off = word_addr % BLOCK_BYTES;
            idx = (word_addr / BLOCK_BYTES) % LINE_COUNT;
            tg = TAG_W'(word_addr / CACHE_BYTES);
            block_base = word_addr - off;
            if (line_valid[idx] && line_tag[idx] == tg) begin
                r.hit = 1'b1;
            end else begin
                if (line_valid[idx] && line_dirty[idx]) begin
                    victim_base = int'(line_tag[idx]) * CACHE_BYTES + idx * BLOCK_BYTES;
                    for (int k = 0; k < BLOCK_BYTES; k++)
                        backing_data[(victim_base + k) % MEMORY_BYTES] =
                            line_data[idx * BLOCK_BYTES + k];
                    elapsed_model += mem_write_cost;
                    r.wrote_back = 1'b1;
                end
                for (int k = 0; k < BLOCK_BYTES; k++)
                    line_data[idx * BLOCK_BYTES + k] = backing_data[block_base + k];
                elapsed_model += mem_read_cost;
                line_valid[idx] = 1'b1;
                line_tag[idx] = tg;
                line_dirty[idx] = 1'b0;
            end
            if (a.op == OP_READ) begin
                for (int k = 0; k < WORD_BYTES; k++)
                    r.read_data[8*k +: 8] =
                        line_data[idx * BLOCK_BYTES + (off + k) % BLOCK_BYTES];
                elapsed_model += l1_read_cost;
            end else begin
                for (int k = 0; k < WORD_BYTES; k++)
                    line_data[idx * BLOCK_BYTES + (off + k) % BLOCK_BYTES] =
                        a.write_data[8*k +: 8];
                elapsed_model += l1_write_cost;
                line_dirty[idx] = 1'b1;
            end
        end
        r.elapsed = elapsed_model;
    endtask

    // Driver: holds each word on the inputs until the block takes it.
    int  gap_left = 0;
    int  burst_left = 0;
    bit  idle_on = 1'b0;

    always @(posedge i_clk) begin
        t_access next_access;
        t_reply  reply;
        logic    next_start;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            next_start = start;
            if (start && !busy) begin
                predict_access('{op: i_op, address: i_address, write_data: i_write_data},
                               reply);
                predicted_replies.push_back(reply);
                words_accepted++;
                next_start = 1'b0;
                if (burst_left == 0) begin
                    burst_left = $urandom_range(20, 120);
                    idle_on = ($urandom_range(0, 2) != 0);
                end
                burst_left--;
                gap_left = idle_on ? $urandom_range(0, 12) : 0;
            end
            if (!next_start) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (access_queue.size() > 0) begin
                    next_access = access_queue.pop_front();
                    i_op <= next_access.op;
                    i_address <= next_access.address;
                    i_write_data <= next_access.write_data;
                    next_start = 1'b1;
                end
            end
            start <= next_start;
        end
    end

    // Monitor: every strobed result is checked against the oldest prediction.
    always @(posedge i_clk) begin
        t_reply want;
        if (i_rst_n && o_done) begin
            if (predicted_replies.size() == 0) begin
                $display("%0t: unexpected result, read_data %h elapsed %0d",
                         $time, o_read_data, o_elapsed);
                mismatch_count++;
            end else begin
                want = predicted_replies.pop_front();
                if (o_read_data !== want.read_data) begin
                    $display("%0t: read_data expected %h actual %h",
                             $time, want.read_data, o_read_data);
                    mismatch_count++;
                end
                if (o_hit !== want.hit) begin
                    $display("%0t: hit expected %b actual %b", $time, want.hit, o_hit);
                    mismatch_count++;
                end
                if (o_wrote_back !== want.wrote_back) begin
                    $display("%0t: wrote_back expected %b actual %b",
                             $time, want.wrote_back, o_wrote_back);
                    mismatch_count++;
                end
                if (o_range_error !== want.range_error) begin
                    $display("%0t: range_error expected %b actual %b",
                             $time, want.range_error, o_range_error);
                    mismatch_count++;
                end
                if (o_elapsed !== want.elapsed) begin
                    $display("%0t: elapsed expected %0d actual %0d",
                             $time, want.elapsed, o_elapsed);
                    mismatch_count++;
                end
            end
        end
    end

    task automatic add_access(input logic [OP_W-1:0] op, input logic [ADDR_W-1:0] address,
                              input logic [DATA_W-1:0] data);
        access_queue.push_back('{op: op, address: address, write_data: data});
        words_queued++;
    endtask

    task automatic wait_idle();
        do @(negedge i_clk);
        while (words_accepted != words_queued || predicted_replies.size() != 0 || busy);
    endtask

    task automatic write_costs(input logic [COST_W-1:0] l1r, input logic [COST_W-1:0] l1w,
                               input logic [COST_W-1:0] mr, input logic [COST_W-1:0] mw);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= CFG_L1_READ;
        i_cfg_data <= l1r;
        l1_read_cost = l1r;
        @(posedge i_clk);
        i_cfg_index <= CFG_L1_WRITE;
        i_cfg_data <= l1w;
        l1_write_cost = l1w;
        @(posedge i_clk);
        i_cfg_index <= CFG_MEM_READ;
        i_cfg_data <= mr;
        mem_read_cost = mr;
        @(posedge i_clk);
        i_cfg_index <= CFG_MEM_WRITE;
        i_cfg_data <= mw;
        mem_write_cost = mw;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    // Most addresses fall in a few tags so that lines hit, conflict and get evicted dirty.
    task automatic add_random_accesses(input int count);
        int pick;
        logic [OP_W-1:0] op;
        logic [ADDR_W-1:0] address;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 46)
                op = OP_READ;
            else if (pick < 92)
                op = OP_WRITE;
            else if (pick < 96)
                op = OP_CLEAR;
            else
                op = OP_UNUSED;
            if ($urandom_range(0, 3) == 0)
                address = ADDR_W'($urandom);
            else
                address = {TAG_W'($urandom_range(0, 3)), IDX_W'($urandom_range(0, 63)),
                           OFF_W'($urandom)};
            add_access(op, address, $urandom);
        end
    endtask

    initial begin
        for (int k = 0; k < CACHE_BYTES; k++)
            line_data[k] = '0;
        for (int k = 0; k < LINE_COUNT; k++) begin
            line_tag[k] = '0;
            line_valid[k] = 1'b0;
            line_dirty[k] = 1'b0;
        end
        for (int k = 0; k < MEMORY_BYTES; k++)
            backing_data[k] = '0;
        elapsed_model = '0;
        l1_read_cost = 8'd1;
        l1_write_cost = 8'd1;
        mem_read_cost = 8'd100;
        mem_write_cost = 8'd100;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait_idle();

        add_access(OP_READ,   16'h0000, 32'h0000_0000);
        add_access(OP_WRITE,  16'h0000, 32'hFFFF_FFFF);
        add_access(OP_READ,   16'h0003, 32'hFFFF_FFFF);
        add_access(OP_WRITE,  16'hFFFF, 32'h1234_5678);
        add_access(OP_READ,   16'hFFFC, 32'h0000_0000);
        add_access(OP_WRITE,  16'h0400, 32'hA5A5_A5A5);
        add_access(OP_READ,   16'h0000, 32'h0000_0000);
        add_access(OP_READ,   16'h0401, 32'h0000_0000);
        add_access(OP_WRITE,  16'h000C, 32'h5A5A_5A5A);
        add_access(OP_WRITE,  16'h0008, 32'h0000_0000);
        add_access(OP_UNUSED, 16'h7FFF, 32'hFFFF_FFFF);
        add_access(OP_CLEAR,  16'h0000, 32'h0000_0000);
        add_access(OP_READ,   16'h03F0, 32'h0000_0000);
        add_access(OP_WRITE,  16'h03F6, 32'h8000_0001);
        add_access(OP_WRITE,  16'hFC00, 32'h0F0F_F0F0);
        add_access(OP_READ,   16'h000E, 32'h0000_0000);
        add_access(OP_READ,   16'hAAAA, 32'hAAAA_AAAA);
        add_access(OP_WRITE,  16'h5555, 32'h5555_5555);
        add_access(OP_READ,   16'h5554, 32'h0000_0000);
        add_access(OP_CLEAR,  16'hFFFF, 32'hFFFF_FFFF);
        add_access(OP_UNUSED, 16'h0000, 32'h0000_0000);
        add_access(OP_READ,   16'hFC02, 32'h0000_0000);
        add_random_accesses(250);
        wait_idle();

        write_costs(8'd0, 8'd0, 8'd0, 8'd0);
        add_random_accesses(250);
        wait_idle();

        write_costs(8'd255, 8'd255, 8'd255, 8'd255);
        add_random_accesses(250);
        wait_idle();

        for (int p = 0; p < 3; p++) begin
            write_costs(COST_W'($urandom), COST_W'($urandom), COST_W'($urandom),
                        COST_W'($urandom));
            add_random_accesses(250);
            wait_idle();
        end

        repeat (10) @(posedge i_clk);
        if (mismatch_count == 0 && predicted_replies.size() == 0) begin
            $display("direct_mapped_write_back_cache_tb passed");
        end else begin
            $display("direct_mapped_write_back_cache_tb failed");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("direct_mapped_write_back_cache_tb failed");
        $finish;
    end

endmodule
